// ===== rtl/core/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

  // Number of register stages between the input and the output beat.
  localparam int unsigned NumStages = 5;

  // Input beat: one pixel in hue / saturation / level form.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] level;
  } pixel_in_t;

  // Output beat: one RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_out_t;

  // Meaning of the level field.
  typedef enum logic {
    MODEL_HSV = 1'b0,
    MODEL_HSL = 1'b1
  } color_model_e;

  // Hue sextant; the name lists the channel that gets the chroma, then the one
  // that gets the triangular weight.
  typedef enum logic [2:0] {
    SEXT_R_G = 3'd0,
    SEXT_G_R = 3'd1,
    SEXT_G_B = 3'd2,
    SEXT_B_G = 3'd3,
    SEXT_B_R = 3'd4,
    SEXT_R_B = 3'd5
  } sextant_e;

  // Reciprocal of 127, scaled by 2**22 and rounded up. It is exact for
  // dividends below 33554, and the HSL chroma correction stays below 32449.
  localparam logic [16:0] Inv127      = 17'd33027;
  localparam int unsigned Inv127Shift = 22;

  // Reciprocal of 255, scaled by 2**25 and rounded up. It is exact for any
  // 17-bit dividend.
  localparam logic [17:0] Inv255      = 18'd131587;
  localparam int unsigned Inv255Shift = 25;

  // First stage: product for the chroma and the folded hue.
  typedef struct packed {
    color_model_e model;
    logic [15:0]  prod;
    logic [7:0]   level;
    logic [8:0]   fold;
    sextant_e     sextant;
  } stage1_t;

  // Second stage: final chroma.
  typedef struct packed {
    color_model_e model;
    logic [15:0]  chroma;
    logic [7:0]   level;
    logic [8:0]   fold;
    sextant_e     sextant;
  } stage2_t;

  // Third stage: chroma, weight and offset, all scaled by 255.
  typedef struct packed {
    logic [15:0]        chroma;
    logic [15:0]        weight;
    logic signed [17:0] offset;
    sextant_e           sextant;
  } stage3_t;

  // Fourth stage: channel sums before the division by 255.
  typedef struct packed {
    logic signed [17:0] sum_r;
    logic signed [17:0] sum_g;
    logic signed [17:0] sum_b;
  } stage4_t;

endpackage

// ===== rtl/core/hsv_hsl_to_rgb_converter.sv =====
// Converts one 8-bit hue / saturation / level pixel to 8-bit RGB per clock
// cycle. The color_model register (cfg_we_i, cfg_wdata_i) selects whether
// level is HSV value (0, the reset value) or HSL lightness (1); write it only
// while no pixel is in flight. The datapath is a five-stage pipeline: chroma
// product, HSL chroma correction, weight and offset, channel sums, and the
// division by 255 into the output register. With out_ready_i held high the
// block takes a new pixel every cycle. Each stage holds its beat only while
// the stage after it is full and stalled, so in_ready_o drops only once the
// whole pipeline has filled up behind a stalled output.
module hsv_hsl_to_rgb_converter import hsvrgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pixel_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pixel_out_t out_data_o
);

  color_model_e                 color_model_q;
  logic         [NumStages-1:0] valid_q;
  logic         [NumStages-1:0] stage_en;
  stage2_t                      stage2;
  stage4_t                      stage4;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_model_q <= MODEL_HSV;
    end else if (cfg_we_i) begin
      color_model_q <= color_model_e'(cfg_wdata_i);
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  // Valid bits that travel along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  hsvrgb_chroma u_chroma (
    .clk_i    (clk_i),
    .en_i     (stage_en[1:0]),
    .model_i  (color_model_q),
    .pix_i    (in_data_i),
    .stage2_o (stage2)
  );

  hsvrgb_mix u_mix (
    .clk_i    (clk_i),
    .en_i     (stage_en[3:2]),
    .stage2_i (stage2),
    .stage4_o (stage4)
  );

  hsvrgb_div255 u_div255 (
    .clk_i    (clk_i),
    .en_i     (stage_en[4]),
    .stage4_i (stage4),
    .pix_o    (out_data_o)
  );

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[NumStages-1];

  // An empty or draining output register never holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled although the output is free");

  // With the output always ready, an accepted beat passes all stage registers and shows up as out_valid_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_ready_i) ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("accepted beat did not reach the output in time");

  // A stalled full output register keeps the beat held in the stage in front of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && valid_q[3]) |=> valid_q[3])
    else $error("beat lost in front of a stalled output");

endmodule

// ===== rtl/core/hsvrgb_chroma.sv =====
module hsvrgb_chroma import hsvrgb_pkg::*; (
  input  logic         clk_i,
  input  logic [1:0]   en_i,
  input  color_model_e model_i,
  input  pixel_in_t    pix_i,
  output stage2_t      stage2_o
);

  stage1_t     s1_d, s1_q;
  stage2_t     s2_d, s2_q;

  logic [10:0] hue_x6;
  logic [8:0]  hue_mod;
  logic [7:0]  light_c0;
  logic [7:0]  mul_a;
  logic [16:0] corr_sum;
  logic [14:0] corr_half;
  logic [31:0] corr_prod;
  logic [7:0]  corr_q;

  // Scale hue by six, split it into sextant and a triangular weight, and form
  // the chroma product.
  always_comb begin
    hue_x6   = {1'b0, pix_i.hue, 2'b00} + {2'b00, pix_i.hue, 1'b0};
    hue_mod  = hue_x6[8:0];
    light_c0 = pix_i.level[7] ? 8'(9'd510 - {pix_i.level, 1'b0})
                              : {pix_i.level[6:0], 1'b0};
    mul_a    = (model_i == MODEL_HSL) ? light_c0 : pix_i.level;

    s1_d.model   = model_i;
    s1_d.prod    = {8'd0, mul_a} * {8'd0, pix_i.saturation};
    s1_d.level   = pix_i.level;
    s1_d.fold    = (hue_mod > 9'd256) ? 9'(10'd512 - {1'b0, hue_mod}) : hue_mod;
    s1_d.sextant = sextant_e'(hue_x6[10:8]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
  end

  // HSL chroma is p*255/254 rounded, that is p + (p+127)/254, and the
  // division by 254 is a halving followed by a reciprocal multiply by 1/127.
  always_comb begin
    corr_sum  = {1'b0, s1_q.prod} + 17'd127;
    corr_half = corr_sum[15:1];
    corr_prod = {17'd0, corr_half} * {15'd0, Inv127};
    corr_q    = corr_prod[Inv127Shift +: 8];

    s2_d.model   = s1_q.model;
    s2_d.chroma  = (s1_q.model == MODEL_HSL) ? s1_q.prod + {8'd0, corr_q} : s1_q.prod;
    s2_d.level   = s1_q.level;
    s2_d.fold    = s1_q.fold;
    s2_d.sextant = s1_q.sextant;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q <= s2_d;
    end
  end

  assign stage2_o = s2_q;

endmodule

// ===== rtl/core/hsvrgb_mix.sv =====
module hsvrgb_mix import hsvrgb_pkg::*; (
  input  logic       clk_i,
  input  logic [1:0] en_i,
  input  stage2_t    stage2_i,
  output stage4_t    stage4_o
);

  stage3_t     s3_d, s3_q;
  stage4_t     s4_d, s4_q;

  logic [24:0] fc_prod;
  logic [24:0] fc_round;
  logic [15:0] level_x255;
  logic [16:0] chroma_inc;
  logic [15:0] offset_sub;
  logic [15:0] term_r, term_g, term_b;

  // Weight x = (fold*c + 127) / 256 and offset m = level*255 - c (HSV) or
  // level*255 - (c+1)/2 (HSL).
  always_comb begin
    fc_prod    = {16'd0, stage2_i.fold} * {9'd0, stage2_i.chroma};
    fc_round   = fc_prod + 25'd127;
    level_x255 = {stage2_i.level, 8'd0} - {8'd0, stage2_i.level};
    chroma_inc = {1'b0, stage2_i.chroma} + 17'd1;
    offset_sub = (stage2_i.model == MODEL_HSL) ? chroma_inc[16:1] : stage2_i.chroma;

    s3_d.chroma  = stage2_i.chroma;
    s3_d.weight  = fc_round[23:8];
    s3_d.offset  = signed'({2'b00, level_x255}) - signed'({2'b00, offset_sub});
    s3_d.sextant = stage2_i.sextant;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s3_q <= s3_d;
    end
  end

  // Route chroma, weight or zero to each channel and add the offset.
  always_comb begin
    case (s3_q.sextant)
      SEXT_R_G: begin
        term_r = s3_q.chroma; term_g = s3_q.weight; term_b = 16'd0;
      end
      SEXT_G_R: begin
        term_r = s3_q.weight; term_g = s3_q.chroma; term_b = 16'd0;
      end
      SEXT_G_B: begin
        term_r = 16'd0; term_g = s3_q.chroma; term_b = s3_q.weight;
      end
      SEXT_B_G: begin
        term_r = 16'd0; term_g = s3_q.weight; term_b = s3_q.chroma;
      end
      SEXT_B_R: begin
        term_r = s3_q.weight; term_g = 16'd0; term_b = s3_q.chroma;
      end
      default: begin
        term_r = s3_q.chroma; term_g = 16'd0; term_b = s3_q.weight;
      end
    endcase

    s4_d.sum_r = s3_q.offset + signed'({2'b00, term_r});
    s4_d.sum_g = s3_q.offset + signed'({2'b00, term_g});
    s4_d.sum_b = s3_q.offset + signed'({2'b00, term_b});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s4_q <= s4_d;
    end
  end

  assign stage4_o = s4_q;

endmodule

// ===== rtl/core/hsvrgb_div255.sv =====
module hsvrgb_div255 import hsvrgb_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  stage4_t    stage4_i,
  output pixel_out_t pix_o
);

  pixel_out_t pix_d, pix_q;

  // Divide a channel sum by 255 through a reciprocal multiply. A sum that is
  // zero or negative gives zero, and a quotient above full scale saturates.
  function automatic logic [7:0] div255(input logic signed [17:0] sum);
    logic [34:0] prod;
    logic [9:0]  quot;
    prod = {18'd0, sum[16:0]} * {17'd0, Inv255};
    quot = prod[Inv255Shift +: 10];
    if (sum[17] || (sum == 18'sd0)) begin
      div255 = 8'd0;
    end else if (quot > 10'd255) begin
      div255 = 8'hff;
    end else begin
      div255 = quot[7:0];
    end
  endfunction

  always_comb begin
    pix_d.red   = div255(stage4_i.sum_r);
    pix_d.green = div255(stage4_i.sum_g);
    pix_d.blue  = div255(stage4_i.sum_b);
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule
